### sv/tlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlp_pkg;

	// Field widths shared by the channel interfaces and the block.
	localparam int unsigned POS_W  = 32;
	localparam int unsigned RATE_W = 31;
	localparam int unsigned DT_W   = 16;

	// Phase of the current move.
	typedef enum logic [2:0] {
		PH_FINISHED = 3'd0,
		PH_START    = 3'd1,
		PH_ACCEL    = 3'd2,
		PH_CRUISE   = 3'd3,
		PH_DECEL    = 3'd4
	} phase_t;

	// Item kinds on the input channel.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_SETUP = 1'b1;

	localparam logic [RATE_W-1:0] ACCEL_RESET = 31'd65536;

endpackage

`default_nettype wire

### sv/tlp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic signed [tlp_pkg::POS_W-1:0]      start_x;
	logic signed [tlp_pkg::POS_W-1:0]      start_y;
	logic signed [tlp_pkg::POS_W-1:0]      target_x;
	logic signed [tlp_pkg::POS_W-1:0]      target_y;
	logic        [tlp_pkg::RATE_W-1:0]     feed_rate;
	logic        [tlp_pkg::DT_W-1:0]       tick_dt;

	modport source (output valid, mode, start_x, start_y, target_x, target_y,
		feed_rate, tick_dt, input ready);
	modport sink (input valid, mode, start_x, start_y, target_x, target_y,
		feed_rate, tick_dt, output ready);
endinterface

interface tlp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tlp_pkg::POS_W-1:0]      pos_x;
	logic signed [tlp_pkg::POS_W-1:0]      pos_y;
	logic signed [tlp_pkg::POS_W-1:0]      vel_x;
	logic signed [tlp_pkg::POS_W-1:0]      vel_y;
	logic signed [tlp_pkg::POS_W-1:0]      acc_x;
	logic signed [tlp_pkg::POS_W-1:0]      acc_y;
	logic                                  done_res;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
		done_res, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
		done_res, output ready);
endinterface

`default_nettype wire

### sv/trapezoid_line_profile.sv
// Throughput: one item at a time; the input is ready only when the sequencer idles.
// One 66-bit add/subtract unit does the long arithmetic a bit per cycle (shift-add multiply,
// restoring divide and square root).
// Reset: asynchronous, clears the move state to finished at the origin, accel 65536.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_line_profile (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [tlp_pkg::RATE_W-1:0]    cfg_wr_data,
	tlp_in_if.sink                             in_ch,
	tlp_out_if.source                          out_ch
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_MAG   = 17'h00002,
		S_SQX   = 17'h00004,
		S_SQY   = 17'h00008,
		S_DIST  = 17'h00010,
		S_FF    = 17'h00020,
		S_MIND  = 17'h00040,
		S_DA    = 17'h00080,
		S_PEAK  = 17'h00100,
		S_TACC  = 17'h00200,
		S_TCRU  = 17'h00400,
		S_TIMES = 17'h00800,
		S_AXM   = 17'h01000,
		S_AXD   = 17'h02000,
		S_TPH   = 17'h04000,
		S_TMUL  = 17'h08000,
		S_OUT   = 17'h10000
	} seq_t;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

	seq_t             state_q;
	tlp_pkg::phase_t  phase_q;
	logic [30:0]      accel_q;

	// Latched item.
	logic [31:0] sx_q, sy_q, tx_q, ty_q;
	logic [30:0] f_q;
	logic [15:0] dt_q;

	// Setup intermediates.
	logic [31:0] magx_q, magy_q;
	logic        negx_q, negy_q;
	logic [30:0] aeff_q;
	logic [63:0] n_q;
	logic [32:0] dist_q;
	logic [61:0] mind_q;
	logic        short_q;
	logic [32:0] peak_q;
	logic [31:0] tcru_q;
	logic [1:0]  idx_q;
	logic        tneg_q;

	// Move state.
	logic [31:0] elapsed_q, aet_q, cet_q, fin_q;
	logic [31:0] cx_q, cy_q, vx_q, vy_q, ax_q, ay_q;
	logic [31:0] ua_q [2];
	logic [31:0] cv_q [2];
	logic [31:0] epx_q, epy_q;

	// Shared unit.
	logic [65:0] ux_q, uy_q, uz_q;
	logic [6:0]  cnt_q;

	logic        out_valid_q;
	logic [31:0] opx_q, opy_q, ovx_q, ovy_q, oax_q, oay_q;
	logic        odone_q;

	function automatic logic [31:0] sat_u32(input logic [65:0] v);
		return (|v[65:32]) ? U32_MAX : v[31:0];
	endfunction

	function automatic logic [31:0] signed_sat(input logic [32:0] q, input logic n);
		logic [31:0] r;
		if (n) r = (q >= 33'h1_0000_0000 || q[31] && |q[30:0] || q[32]) ?
			S32_MIN : 32'(-q[31:0]);
		else r = (q > 33'(S32_MAX)) ? S32_MAX : q[31:0];
		return r;
	endfunction

	function automatic logic [31:0] neg_sat(input logic [31:0] v);
		return (v == S32_MIN) ? S32_MAX : 32'(-v);
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	// ---------------- shared add/subtract unit ----------------
	logic        u_mul, u_div;
	logic [65:0] r_div, r_sqrt, lhs, rhs;
	logic        sub;
	logic [66:0] usum;
	logic        ge;

	always_comb begin
		u_mul = (state_q == S_SQX) || (state_q == S_SQY) || (state_q == S_FF) ||
			(state_q == S_DA) || (state_q == S_AXM) || (state_q == S_TMUL);
		u_div = (state_q == S_MIND) || (state_q == S_TACC) || (state_q == S_TCRU) ||
			(state_q == S_AXD);
		r_div  = {uz_q[64:0], ux_q[65]};
		r_sqrt = {uz_q[63:0], ux_q[65:64]};
		if (u_mul) begin
			lhs = uz_q;
			rhs = ux_q;
			sub = 1'b0;
		end else if (u_div) begin
			lhs = r_div;
			rhs = uy_q;
			sub = 1'b1;
		end else begin
			lhs = r_sqrt;
			rhs = {uy_q[63:0], 2'b01};
			sub = 1'b1;
		end
		usum = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + 67'(sub);
		// Carry out of a subtract means no borrow.
		ge = usum[66];
	end

	// ---------------- setup helpers ----------------
	logic [32:0] dx_c, dy_c;
	logic [31:0] magx_c, magy_c;
	logic [64:0] nsum_c;
	logic [31:0] cet_c, fin_c;
	logic [1:0]  nidx_c;
	logic [65:0] ax_mcand_c;
	logic [31:0] ax_mag_c;
	logic [32:0] axq_c;

	always_comb begin
		dx_c   = {tx_q[31], tx_q} - {sx_q[31], sx_q};
		dy_c   = {ty_q[31], ty_q} - {sy_q[31], sy_q};
		magx_c = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
		magy_c = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
		nsum_c = {1'b0, n_q} + {1'b0, uz_q[63:0]};
		cet_c  = sat_u32(66'(aet_q) + 66'(tcru_q));
		fin_c  = sat_u32(66'(aet_q) + 66'(cet_c));
		nidx_c = idx_q + 2'd1;
		ax_mcand_c = nidx_c[1] ? 66'(aeff_q) : 66'(peak_q);
		ax_mag_c   = nidx_c[0] ? magy_q : magx_q;
		axq_c  = ux_q[32:0];
	end

	// ---------------- tick phase resolution ----------------
	logic [31:0]     el_c, nvx, nvy, nax, nay, ncx, ncy;
	tlp_pkg::phase_t nph;
	logic            t_int, t_acc, settled;
	logic [31:0]     t_op_c;

	always_comb begin
		el_c = sat_u32(66'(elapsed_q) + 66'(dt_q));
		nph = phase_q;
		nvx = vx_q; nvy = vy_q; nax = ax_q; nay = ay_q; ncx = cx_q; ncy = cy_q;
		t_int = 1'b0;
		t_acc = 1'b0;
		settled = 1'b0;
		if (nph == tlp_pkg::PH_START) begin
			nvx = '0; nvy = '0; nax = ua_q[0]; nay = ua_q[1];
			nph = tlp_pkg::PH_ACCEL;
		end
		if (nph == tlp_pkg::PH_ACCEL) begin
			if (el_c <= aet_q) begin
				t_int = 1'b1; t_acc = 1'b1; settled = 1'b1;
			end else begin
				nvx = cv_q[0]; nvy = cv_q[1]; nax = '0; nay = '0;
				nph = tlp_pkg::PH_CRUISE;
			end
		end
		if (!settled && nph == tlp_pkg::PH_CRUISE) begin
			if (el_c <= cet_q) begin
				t_int = 1'b1; settled = 1'b1;
			end else begin
				nax = neg_sat(ua_q[0]); nay = neg_sat(ua_q[1]);
				nph = tlp_pkg::PH_DECEL;
			end
		end
		if (!settled && nph == tlp_pkg::PH_DECEL && el_c <= fin_q) begin
			t_int = 1'b1; t_acc = 1'b1; settled = 1'b1;
		end
		if (!settled) begin
			nvx = '0; nvy = '0; nax = '0; nay = '0;
			ncx = epx_q; ncy = epy_q;
			nph = tlp_pkg::PH_FINISHED;
		end
		t_op_c = t_acc ? nax : nvx;
	end

	// ---------------- tick integration step ----------------
	logic [32:0] tm_c;
	logic [31:0] tgt_c, tnext_c, top_next_c;
	logic [33:0] ts_c;

	always_comb begin
		tm_c = tneg_q ? 33'((49'(uz_q[47:0]) + 49'd65535) >> 16) : 33'(uz_q[47:16]);
		case (idx_q)
			2'd0:    tgt_c = vx_q;
			2'd1:    tgt_c = vy_q;
			2'd2:    tgt_c = cx_q;
			default: tgt_c = cy_q;
		endcase
		ts_c = tneg_q ? ({{2{tgt_c[31]}}, tgt_c} - {1'b0, tm_c}) :
			({{2{tgt_c[31]}}, tgt_c} + {1'b0, tm_c});
		if (ts_c[33:31] == 3'b000 || ts_c[33:31] == 3'b111) tnext_c = ts_c[31:0];
		else tnext_c = ts_c[33] ? S32_MIN : S32_MAX;
		// Operand of the following step; velocities are already updated by then.
		case (nidx_c)
			2'd1:    top_next_c = ay_q;
			2'd2:    top_next_c = vx_q;
			default: top_next_c = vy_q;
		endcase
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ch.ready;

	logic out_load;
	assign out_load = (state_q == S_OUT) && (cnt_q == 7'd0) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= tlp_pkg::PH_FINISHED;
			accel_q <= tlp_pkg::ACCEL_RESET;
			elapsed_q <= '0; aet_q <= '0; cet_q <= '0; fin_q <= '0;
			cx_q <= '0; cy_q <= '0; vx_q <= '0; vy_q <= '0; ax_q <= '0; ay_q <= '0;
			ua_q[0] <= '0; ua_q[1] <= '0; cv_q[0] <= '0; cv_q[1] <= '0;
			epx_q <= '0; epy_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) accel_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;

			if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
				if (u_mul) begin
					if (uy_q[0]) uz_q <= usum[65:0];
					ux_q <= {ux_q[64:0], 1'b0};
					uy_q <= {1'b0, uy_q[65:1]};
				end else if (u_div) begin
					uz_q <= ge ? usum[65:0] : r_div;
					ux_q <= {ux_q[64:0], ge};
				end else begin
					uz_q <= ge ? usum[65:0] : r_sqrt;
					uy_q <= {uy_q[64:0], ge};
					ux_q <= {ux_q[63:0], 2'b00};
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_ch.valid) begin
							sx_q <= in_ch.start_x; sy_q <= in_ch.start_y;
							tx_q <= in_ch.target_x; ty_q <= in_ch.target_y;
							f_q  <= in_ch.feed_rate; dt_q <= in_ch.tick_dt;
							if (in_ch.mode == tlp_pkg::MODE_SETUP) state_q <= S_MAG;
							else if (phase_q == tlp_pkg::PH_FINISHED) state_q <= S_OUT;
							else state_q <= S_TPH;
						end
					end
					S_MAG: begin
						magx_q <= magx_c; magy_q <= magy_c;
						negx_q <= dx_c[32]; negy_q <= dy_c[32];
						aeff_q <= (accel_q == '0) ? 31'd1 : accel_q;
						ux_q <= 66'(magx_c); uy_q <= 66'(magx_c); uz_q <= '0; cnt_q <= 7'd32;
						state_q <= S_SQX;
					end
					S_SQX: begin
						n_q <= uz_q[63:0];
						ux_q <= 66'(magy_q); uy_q <= 66'(magy_q); uz_q <= '0; cnt_q <= 7'd32;
						state_q <= S_SQY;
					end
					S_SQY: begin
						ux_q <= 66'(nsum_c); uy_q <= '0; uz_q <= '0; cnt_q <= 7'd33;
						state_q <= S_DIST;
					end
					S_DIST: begin
						dist_q <= uy_q[32:0];
						elapsed_q <= '0;
						epx_q <= tx_q; epy_q <= ty_q;
						vx_q <= '0; vy_q <= '0; ax_q <= '0; ay_q <= '0;
						if (uy_q[32:0] == '0) begin
							// A zero-length move is finished at once.
							ua_q[0] <= '0; ua_q[1] <= '0; cv_q[0] <= '0; cv_q[1] <= '0;
							aet_q <= '0; cet_q <= '0; fin_q <= '0;
							cx_q <= tx_q; cy_q <= ty_q;
							phase_q <= tlp_pkg::PH_FINISHED;
							state_q <= S_OUT;
						end else begin
							cx_q <= sx_q; cy_q <= sy_q;
							phase_q <= tlp_pkg::PH_START;
							ux_q <= 66'(f_q); uy_q <= 66'(f_q); uz_q <= '0; cnt_q <= 7'd31;
							state_q <= S_FF;
						end
					end
					S_FF: begin
						ux_q <= uz_q; uy_q <= 66'(aeff_q); uz_q <= '0; cnt_q <= 7'd66;
						state_q <= S_MIND;
					end
					S_MIND: begin
						mind_q <= ux_q[61:0];
						short_q <= (ux_q >= 66'(dist_q));
						uz_q <= '0;
						if (ux_q >= 66'(dist_q)) begin
							ux_q <= 66'(dist_q); uy_q <= 66'(aeff_q); cnt_q <= 7'd31;
							state_q <= S_DA;
						end else begin
							peak_q <= 33'(f_q);
							ux_q <= {19'd0, f_q, 16'd0}; uy_q <= 66'(aeff_q); cnt_q <= 7'd66;
							state_q <= S_TACC;
						end
					end
					S_DA: begin
						ux_q <= uz_q; uy_q <= '0; uz_q <= '0; cnt_q <= 7'd33;
						state_q <= S_PEAK;
					end
					S_PEAK: begin
						peak_q <= uy_q[32:0];
						ux_q <= {17'd0, uy_q[32:0], 16'd0}; uy_q <= 66'(aeff_q);
						uz_q <= '0; cnt_q <= 7'd66;
						state_q <= S_TACC;
					end
					S_TACC: begin
						aet_q <= sat_u32(ux_q);
						uz_q <= '0;
						if (short_q) begin
							tcru_q <= '0;
							state_q <= S_TIMES;
						end else if (f_q == '0) begin
							// No feed: the cruise never ends on its own.
							tcru_q <= U32_MAX;
							state_q <= S_TIMES;
						end else begin
							ux_q <= {(66'(dist_q) - 66'(mind_q))}  << 16;
							uy_q <= 66'(f_q); cnt_q <= 7'd66;
							state_q <= S_TCRU;
						end
					end
					S_TCRU: begin
						tcru_q <= sat_u32(ux_q);
						state_q <= S_TIMES;
					end
					S_TIMES: begin
						cet_q <= cet_c; fin_q <= fin_c;
						idx_q <= 2'd0;
						ux_q <= 66'(peak_q); uy_q <= 66'(magx_q); uz_q <= '0; cnt_q <= 7'd32;
						state_q <= S_AXM;
					end
					S_AXM: begin
						ux_q <= uz_q; uy_q <= 66'(dist_q); uz_q <= '0; cnt_q <= 7'd66;
						state_q <= S_AXD;
					end
					S_AXD: begin
						case (idx_q)
							2'd0:    cv_q[0] <= signed_sat(axq_c, negx_q);
							2'd1:    cv_q[1] <= signed_sat(axq_c, negy_q);
							2'd2:    ua_q[0] <= signed_sat(axq_c, negx_q);
							default: ua_q[1] <= signed_sat(axq_c, negy_q);
						endcase
						if (idx_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							idx_q <= nidx_c;
							ux_q <= ax_mcand_c; uy_q <= 66'(ax_mag_c); uz_q <= '0;
							cnt_q <= 7'd32;
							state_q <= S_AXM;
						end
					end
					S_TPH: begin
						elapsed_q <= el_c;
						phase_q <= nph;
						vx_q <= nvx; vy_q <= nvy; ax_q <= nax; ay_q <= nay;
						cx_q <= ncx; cy_q <= ncy;
						if (t_int) begin
							idx_q <= t_acc ? 2'd0 : 2'd2;
							tneg_q <= t_op_c[31];
							ux_q <= 66'(abs32(t_op_c)); uy_q <= 66'(dt_q); uz_q <= '0;
							cnt_q <= 7'd16;
							state_q <= S_TMUL;
						end else begin
							state_q <= S_OUT;
						end
					end
					S_TMUL: begin
						case (idx_q)
							2'd0:    vx_q <= tnext_c;
							2'd1:    vy_q <= tnext_c;
							2'd2:    cx_q <= tnext_c;
							default: cy_q <= tnext_c;
						endcase
						if (idx_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							idx_q <= nidx_c;
							tneg_q <= top_next_c[31];
							ux_q <= 66'(abs32(top_next_c)); uy_q <= 66'(dt_q); uz_q <= '0;
							cnt_q <= 7'd16;
						end
					end
					S_OUT: begin
						if (out_free) begin
							opx_q <= cx_q; opy_q <= cy_q; ovx_q <= vx_q; ovy_q <= vy_q;
							oax_q <= ax_q; oay_q <= ay_q;
							odone_q <= (phase_q == tlp_pkg::PH_FINISHED);
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign in_ch.ready     = (state_q == S_IDLE) && (cnt_q == 7'd0);
	assign out_ch.valid    = out_valid_q;
	assign out_ch.pos_x    = opx_q;
	assign out_ch.pos_y    = opy_q;
	assign out_ch.vel_x    = ovx_q;
	assign out_ch.vel_y    = ovy_q;
	assign out_ch.acc_x    = oax_q;
	assign out_ch.acc_y    = oay_q;
	assign out_ch.done_res = odone_q;

endmodule

`default_nettype wire
